/* rtl/xpf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpf_pkg
// Shared types, constants and helpers for the two-layer XOR parity encoder.
// ----------------------------------------------------------------------------
package xpf_pkg;

   // payload words per frame
   localparam int FRAME_WORDS = 20;

   localparam int ADDR_W = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
   localparam int CNT_W  = $clog2(FRAME_WORDS + 1);
   localparam int POS_W  = 6;
   localparam int SEQ_W  = 32;
   localparam int WORD_W = 64;
   localparam int GRP_W  = 5;
   localparam int HELD_W = 4;

   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_WORDS - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(FRAME_WORDS);
   localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(FRAME_WORDS - 1);
   localparam logic [GRP_W-1:0] GRP_MIN   = GRP_W'(1);
   localparam logic [GRP_W-1:0] GRP_MAX   = GRP_W'(16);
   localparam logic [GRP_W-1:0] SMALL_RST = GRP_W'(2);
   localparam logic [GRP_W-1:0] LARGE_RST = GRP_W'(4);

   // result kinds
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_PARITY = 1'b1;

   // configuration register indexes
   localparam logic CSR_SMALL_SIZE = 1'b0;
   localparam logic CSR_LARGE_SIZE = 1'b1;

   // parity layers
   localparam logic LAYER_SMALL = 1'b0;
   localparam logic LAYER_LARGE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DATA,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      logic              re;
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] wdata;
   } ram_req_type;

   typedef struct packed {
      logic              packet_kind;
      logic [SEQ_W-1:0]  seq_or_base;
      logic [GRP_W-1:0]  group_count;
      logic [POS_W-1:0]  word_index;
      logic [WORD_W-1:0] out_word;
      logic              run_last;
   } beat_type;

   // zero acts as one, anything above sixteen saturates
   function automatic logic [GRP_W-1:0] clamp_size(input logic [GRP_W-1:0] s);
      logic [GRP_W-1:0] r;
      r = s;
      if (s == '0) begin
         r = GRP_MIN;
      end else if (s > GRP_MAX) begin
         r = GRP_MAX;
      end
      return r;
   endfunction

endpackage

/* rtl/xpf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpf_ram
// One parity store: single port, registered read, read-before-write.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module xpf_ram
   import xpf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ram_req_type       req,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0]      mem [FRAME_WORDS];
   logic [FRAME_WORDS-1:0] valid_ff;
   logic [FRAME_WORDS-1:0] valid_in;
   logic [WORD_W-1:0]      rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req.we) begin
         valid_in[req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.addr] <= req.wdata;
      end
      if (req.re) begin
         rd_data_ff <= valid_ff[req.addr] ? mem[req.addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/xpf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpf_ctrl
// Sequencer: read-modify-write of both stores per word, group counting,
// and the parity sweeps that read out and clear a store.
// ----------------------------------------------------------------------------
module xpf_ctrl
   import xpf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [SEQ_W-1:0]  req_frame_seq,
   input  logic [WORD_W-1:0] req_payload_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [GRP_W-1:0]  csr_write_data,
   input  logic [WORD_W-1:0] small_rd,
   input  logic [WORD_W-1:0] large_rd,
   output ram_req_type       small_req,
   output ram_req_type       large_req,
   input  logic              out_free,
   output logic              beat_load,
   output beat_type          beat
);

   state_type state_ff, state_in;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [HELD_W-1:0] s_held_ff, s_held_in, l_held_ff, l_held_in;
   logic [GRP_W-1:0]  s_size_ff, s_size_in, l_size_ff, l_size_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              close_l_ff, close_l_in;
   logic              layer_ff, layer_in;
   logic [CNT_W-1:0]  iss_cnt_ff, iss_cnt_in, out_cnt_ff, out_cnt_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [SEQ_W-1:0]  s_base_ff, s_base_in, l_base_ff, l_base_in;
   logic [GRP_W-1:0]  s_cnt_ff, s_cnt_in, l_cnt_ff, l_cnt_in;

   logic             last_word;
   logic [GRP_W-1:0] s_count, l_count;
   logic             close_s, close_l;
   logic             take, issue, sweep_done;
   ram_req_type      sweep_req;

   assign last_word = (pos_ff == POS_LAST);
   assign s_count   = {1'b0, s_held_ff} + GRP_MIN;
   assign l_count   = {1'b0, l_held_ff} + GRP_MIN;
   assign close_s   = last_word && (s_count >= clamp_size(s_size_ff));
   assign close_l   = last_word && (l_count >= clamp_size(l_size_ff));

   // sweep pipeline: one read in flight, held in the RAM read register
   assign take       = (state_ff == ST_SWEEP) && rd_pend_ff && out_free;
   assign issue      = (state_ff == ST_SWEEP) && (iss_cnt_ff != CNT_FULL)
                       && (!rd_pend_ff || take);
   assign sweep_done = take && (out_cnt_ff == CNT_LAST);

   assign csr_ready = 1'b1;

   always_comb begin
      sweep_req.re    = issue;
      sweep_req.we    = issue;
      sweep_req.addr  = iss_cnt_ff[ADDR_W-1:0];
      sweep_req.wdata = '0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (out_free) begin
               state_in = (close_s || close_l) ? ST_SWEEP : ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (sweep_done && !(layer_ff == LAYER_SMALL && close_l_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready  = 1'b0;
      small_req  = '0;
      large_req  = '0;
      beat_load  = 1'b0;
      beat       = '0;
      pos_in     = pos_ff;
      s_held_in  = s_held_ff;
      l_held_in  = l_held_ff;
      s_size_in  = s_size_ff;
      l_size_in  = l_size_ff;
      seq_in     = seq_ff;
      word_in    = word_ff;
      close_l_in = close_l_ff;
      layer_in   = layer_ff;
      iss_cnt_in = iss_cnt_ff;
      out_cnt_in = out_cnt_ff;
      rd_pend_in = rd_pend_ff;
      s_base_in  = s_base_ff;
      l_base_in  = l_base_ff;
      s_cnt_in   = s_cnt_ff;
      l_cnt_in   = l_cnt_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_SMALL_SIZE: s_size_in = csr_write_data;
            CSR_LARGE_SIZE: l_size_in = csr_write_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               small_req.re   = 1'b1;
               small_req.addr = pos_ff[ADDR_W-1:0];
               large_req.re   = 1'b1;
               large_req.addr = pos_ff[ADDR_W-1:0];
               seq_in         = req_frame_seq;
               word_in        = req_payload_word;
            end
         end
         ST_DATA: begin
            if (out_free) begin
               small_req.we    = 1'b1;
               small_req.addr  = pos_ff[ADDR_W-1:0];
               small_req.wdata = small_rd ^ word_ff;
               large_req.we    = 1'b1;
               large_req.addr  = pos_ff[ADDR_W-1:0];
               large_req.wdata = large_rd ^ word_ff;

               beat_load        = 1'b1;
               beat.packet_kind = KIND_DATA;
               beat.seq_or_base = seq_ff;
               beat.group_count = '0;
               beat.word_index  = pos_ff;
               beat.out_word    = word_ff;
               beat.run_last    = !(close_s || close_l);

               pos_in = last_word ? '0 : pos_ff + POS_W'(1);
               if (last_word) begin
                  s_held_in = close_s ? '0 : s_count[HELD_W-1:0];
                  l_held_in = close_l ? '0 : l_count[HELD_W-1:0];
               end
               // first covered frame: seq minus frames held before this one
               s_base_in  = seq_ff - {{(SEQ_W-HELD_W){1'b0}}, s_held_ff};
               l_base_in  = seq_ff - {{(SEQ_W-HELD_W){1'b0}}, l_held_ff};
               s_cnt_in   = s_count;
               l_cnt_in   = l_count;
               close_l_in = close_l;
               layer_in   = close_s ? LAYER_SMALL : LAYER_LARGE;
               iss_cnt_in = '0;
               out_cnt_in = '0;
               rd_pend_in = 1'b0;
            end
         end
         ST_SWEEP: begin
            if (layer_ff == LAYER_SMALL) begin
               small_req = sweep_req;
            end else begin
               large_req = sweep_req;
            end
            if (issue) begin
               iss_cnt_in = iss_cnt_ff + CNT_W'(1);
            end
            rd_pend_in = issue || (rd_pend_ff && !take);
            if (take) begin
               beat_load        = 1'b1;
               beat.packet_kind = KIND_PARITY;
               beat.word_index  = POS_W'(out_cnt_ff);
               if (layer_ff == LAYER_SMALL) begin
                  beat.seq_or_base = s_base_ff;
                  beat.group_count = s_cnt_ff;
                  beat.out_word    = small_rd;
                  beat.run_last    = sweep_done && !close_l_ff;
               end else begin
                  beat.seq_or_base = l_base_ff;
                  beat.group_count = l_cnt_ff;
                  beat.out_word    = large_rd;
                  beat.run_last    = sweep_done;
               end
               out_cnt_in = out_cnt_ff + CNT_W'(1);
               if (sweep_done && layer_ff == LAYER_SMALL && close_l_ff) begin
                  layer_in   = LAYER_LARGE;
                  iss_cnt_in = '0;
                  out_cnt_in = '0;
                  rd_pend_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pos_ff     <= '0;
         s_held_ff  <= '0;
         l_held_ff  <= '0;
         s_size_ff  <= SMALL_RST;
         l_size_ff  <= LARGE_RST;
         close_l_ff <= 1'b0;
         layer_ff   <= LAYER_SMALL;
         iss_cnt_ff <= '0;
         out_cnt_ff <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         s_held_ff  <= s_held_in;
         l_held_ff  <= l_held_in;
         s_size_ff  <= s_size_in;
         l_size_ff  <= l_size_in;
         close_l_ff <= close_l_in;
         layer_ff   <= layer_in;
         iss_cnt_ff <= iss_cnt_in;
         out_cnt_ff <= out_cnt_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff    <= seq_in;
      word_ff   <= word_in;
      s_base_ff <= s_base_in;
      l_base_ff <= l_base_in;
      s_cnt_ff  <= s_cnt_in;
      l_cnt_ff  <= l_cnt_in;
   end

endmodule

/* rtl/two_layer_xor_parity_fec_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_layer_xor_parity_fec_core
// Two-layer XOR parity encoder: passes each word through and appends the
// parity words of a small and a large frame group when a group closes.
// ----------------------------------------------------------------------------
// Data path: on accept both stores are read (ST_IDLE); in ST_DATA, once the
//   output register is free, the data beat loads and the XOR write-back is
//   done; only then is a new word taken. Each closing group's store is swept,
//   one parity beat per cycle from its read port while the output is free.
// Reset: synchronous; clears sequencer, counts and sizes (2 and 4); store
//   entries read as zero until rewritten (per-entry valid bits).
// ----------------------------------------------------------------------------
module two_layer_xor_parity_fec_core
   import xpf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [SEQ_W-1:0]  req_frame_seq,
   input  logic [WORD_W-1:0] req_payload_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_packet_kind,
   output logic [SEQ_W-1:0]  rsp_seq_or_base,
   output logic [GRP_W-1:0]  rsp_group_count,
   output logic [POS_W-1:0]  rsp_word_index,
   output logic [WORD_W-1:0] rsp_out_word,
   output logic              rsp_run_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [GRP_W-1:0]  csr_write_data
);

   ram_req_type       small_req, large_req;
   logic [WORD_W-1:0] small_rd, large_rd;
   logic              out_free, beat_load;
   beat_type          beat;
   logic              rsp_valid_ff, rsp_valid_in;
   beat_type          rsp_beat_ff;

   xpf_ram u_small_store (
      .clock   (clock),
      .reset   (reset),
      .req     (small_req),
      .rd_data (small_rd)
   );

   xpf_ram u_large_store (
      .clock   (clock),
      .reset   (reset),
      .req     (large_req),
      .rd_data (large_rd)
   );

   xpf_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_frame_seq    (req_frame_seq),
      .req_payload_word (req_payload_word),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .small_rd         (small_rd),
      .large_rd         (large_rd),
      .small_req        (small_req),
      .large_req        (large_req),
      .out_free         (out_free),
      .beat_load        (beat_load),
      .beat             (beat)
   );

   // output register
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = beat_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_load) begin
         rsp_beat_ff <= beat;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packet_kind = rsp_beat_ff.packet_kind;
   assign rsp_seq_or_base = rsp_beat_ff.seq_or_base;
   assign rsp_group_count = rsp_beat_ff.group_count;
   assign rsp_word_index  = rsp_beat_ff.word_index;
   assign rsp_out_word    = rsp_beat_ff.out_word;
   assign rsp_run_last    = rsp_beat_ff.run_last;

   // no beat may overwrite one still waiting
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      beat_load |-> out_free)
      else $error("beat loaded over a pending result");

   // one word in flight at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word accepted while first in flight");

   a_parity_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_packet_kind == KIND_PARITY)
         |-> (rsp_group_count != '0 && rsp_group_count <= GRP_MAX))
      else $error("parity beat with bad group count");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_packet_kind == KIND_DATA) |-> (rsp_group_count == '0))
      else $error("data beat with nonzero group count");

endmodule
